// ===== design/packed_quaternion_decode_top_assert.svh =====
// ----------------------------------------------------------------------------
// Packed quaternion decode assertion macros
// Concurrent check macros; they expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_QUATERNION_DECODE_TOP_ASSERT_SVH
`define PACKED_QUATERNION_DECODE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define PQD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define PQD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PQD_ASSERT(lbl, clk, rstn, prop, msg)

`define PQD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/pqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed quaternion decode package
// Shared formats, derived widths and types of the smallest-three decoder.
// ----------------------------------------------------------------------------
package pqd_pkg;

    // Packed word format
    localparam int WORD_BITS     = 32;
    localparam int CODE_BITS     = 10;
    localparam int N_CODES       = 3;
    localparam int SLOT_LSB      = 30;
    localparam int SLOT_BITS     = 2;
    localparam int EXT_BITS      = WORD_BITS + N_CODES * CODE_BITS;

    // Result format
    localparam int OUT_FRAC_BITS = 15;
    localparam int OUT_BITS      = 16;
    localparam int N_LANES       = N_CODES + 1;

    // Code scale: M = 2^CODE_BITS - 1, denominator M^2
    localparam int CODE_MAX      = (1 << CODE_BITS) - 1;
    localparam int DEN           = CODE_MAX * CODE_MAX;
    localparam int SQR_BITS      = 2 * CODE_BITS;
    localparam int SUM_BITS      = SQR_BITS + 2;
    localparam int V_BITS        = SQR_BITS + 1;

    // Root search: largest s with s^2 * DEN <= V << SHIFT
    localparam int SHIFT         = 2 * OUT_FRAC_BITS + 1;
    localparam int R_BITS        = V_BITS + SHIFT;
    localparam int ROOT_BITS     = OUT_FRAC_BITS + 1;

    // Saturation limits of the result magnitude
    localparam int OUT_MAX       = (1 << (OUT_BITS - 1)) - 1;
    localparam int POS_CAP       = ((1 << OUT_FRAC_BITS) - 1 < OUT_MAX) ?
                                   (1 << OUT_FRAC_BITS) - 1 : OUT_MAX;
    localparam int NEG_CAP       = ((1 << OUT_FRAC_BITS) < OUT_MAX + 1) ?
                                   (1 << OUT_FRAC_BITS) : OUT_MAX + 1;

    // Position of the rebuilt component in w,x,y,z order
    typedef enum logic [SLOT_BITS-1:0] {
        SLOT_W = 2'd0,
        SLOT_X = 2'd1,
        SLOT_Y = 2'd2,
        SLOT_Z = 2'd3
    } t_slot;

    typedef logic [R_BITS-1:0] t_wide;

    // Data handed from one root cell to the next
    typedef struct packed {
        t_wide                 rem;
        t_wide                 acc;
        logic [ROOT_BITS-1:0]  root;
    } t_root_st;

    // Side information that travels beside the root chain
    typedef struct packed {
        t_slot                 slot;
        logic [N_CODES-1:0]    neg;
    } t_tag;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] quat_w;
        logic signed [OUT_BITS-1:0] quat_x;
        logic signed [OUT_BITS-1:0] quat_y;
        logic signed [OUT_BITS-1:0] quat_z;
    } t_quat;

endpackage

// ===== design/pqd_if.sv =====
// ----------------------------------------------------------------------------
// Packed quaternion decode channels
// Valid/ready channels for the packed word and the decoded quaternion.
// ----------------------------------------------------------------------------
interface pqd_rot_if;
    logic                           valid;
    logic                           ready;
    logic [pqd_pkg::WORD_BITS-1:0]  packed_rotation;

    modport source (output valid, output packed_rotation, input ready);
    modport sink   (input valid, input packed_rotation, output ready);
endinterface

interface pqd_quat_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pqd_pkg::OUT_BITS-1:0]  quat_w;
    logic signed [pqd_pkg::OUT_BITS-1:0]  quat_x;
    logic signed [pqd_pkg::OUT_BITS-1:0]  quat_y;
    logic signed [pqd_pkg::OUT_BITS-1:0]  quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

// ===== design/pqd_front.sv =====
// ----------------------------------------------------------------------------
// Packed quaternion decode front end
// Two stages: code split and squares, then sum of squares and remainder.
// ----------------------------------------------------------------------------
module pqd_front (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [pqd_pkg::WORD_BITS-1:0]  i_word,
    output logic [pqd_pkg::V_BITS-1:0]     o_v [pqd_pkg::N_LANES],
    output pqd_pkg::t_tag                  o_tag
);

    logic [pqd_pkg::EXT_BITS-1:0]   ext_word;
    logic [pqd_pkg::CODE_BITS:0]    twice [pqd_pkg::N_CODES];
    logic [pqd_pkg::CODE_BITS:0]    diff  [pqd_pkg::N_CODES];
    logic [pqd_pkg::CODE_BITS-1:0]  mag   [pqd_pkg::N_CODES];
    logic [pqd_pkg::N_CODES-1:0]    n_neg;

    logic [pqd_pkg::SQR_BITS-1:0]   r_sq  [pqd_pkg::N_CODES];
    logic [pqd_pkg::N_CODES-1:0]    r_neg;
    pqd_pkg::t_slot                 r_slot;

    logic [pqd_pkg::SUM_BITS-1:0]   sum_sq;
    logic [pqd_pkg::V_BITS-1:0]     n_rem;

    logic [pqd_pkg::V_BITS-1:0]     r_v   [pqd_pkg::N_LANES];
    pqd_pkg::t_tag                  r_tag;

    localparam logic [pqd_pkg::CODE_BITS:0] MAXC =
        (pqd_pkg::CODE_BITS + 1)'(pqd_pkg::CODE_MAX);
    localparam logic [pqd_pkg::SUM_BITS-1:0] TWO_DEN =
        pqd_pkg::SUM_BITS'(2 * pqd_pkg::DEN);

    // Split codes (bits past the word read as zero) and fold 2c - M to sign/magnitude
    assign ext_word = {{(pqd_pkg::EXT_BITS - pqd_pkg::WORD_BITS){1'b0}}, i_word};

    always_comb begin
        for (int i = 0; i < pqd_pkg::N_CODES; i++) begin
            twice[i] = {ext_word[i*pqd_pkg::CODE_BITS +: pqd_pkg::CODE_BITS], 1'b0};
            if (twice[i] > MAXC) begin
                diff[i]  = twice[i] - MAXC;
                n_neg[i] = 1'b0;
            end else begin
                diff[i]  = MAXC - twice[i];
                n_neg[i] = 1'b1;
            end
            mag[i] = diff[i][pqd_pkg::CODE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < pqd_pkg::N_CODES; i++) begin
                r_sq[i] <= pqd_pkg::SQR_BITS'(mag[i]) * pqd_pkg::SQR_BITS'(mag[i]);
            end
            r_neg  <= n_neg;
            r_slot <= pqd_pkg::t_slot'(i_word[pqd_pkg::SLOT_LSB +: pqd_pkg::SLOT_BITS]);
        end
    end

    // One minus the sum of squares, in units of 1 / (2 M^2); clamp at zero
    always_comb begin
        sum_sq = pqd_pkg::SUM_BITS'(r_sq[0]) + pqd_pkg::SUM_BITS'(r_sq[1])
               + pqd_pkg::SUM_BITS'(r_sq[2]);
        if (sum_sq >= TWO_DEN) begin
            n_rem = '0;
        end else begin
            n_rem = pqd_pkg::V_BITS'(TWO_DEN - sum_sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < pqd_pkg::N_CODES; i++) begin
                r_v[i] <= pqd_pkg::V_BITS'(r_sq[i]);
            end
            r_v[pqd_pkg::N_CODES] <= n_rem;
            r_tag.slot <= r_slot;
            r_tag.neg  <= r_neg;
        end
    end

    assign o_v   = r_v;
    assign o_tag = r_tag;

endmodule

// ===== design/pqd_root_cell.sv =====
// ----------------------------------------------------------------------------
// Packed quaternion decode root cell
// Resolves one bit of s in s^2 * M^2 <= V << SHIFT and hands on the rest.
// ----------------------------------------------------------------------------
module pqd_root_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  pqd_pkg::t_wide     i_step,
    input  pqd_pkg::t_root_st  i_st,
    output pqd_pkg::t_root_st  o_st
);

    // i_step is M^2 * 4^k for this cell's bit k; acc is (s * M^2) << (k + 1)
    logic [pqd_pkg::R_BITS:0]  delta;
    logic                      take;
    pqd_pkg::t_root_st         n_st;
    pqd_pkg::t_root_st         r_st;

    always_comb begin
        delta = {1'b0, i_st.acc} + {1'b0, i_step};
        take  = (delta <= {1'b0, i_st.rem});
        n_st.rem  = take ? (i_st.rem - delta[pqd_pkg::R_BITS-1:0]) : i_st.rem;
        // rescale acc for the next bit down, adding the new bit's share
        n_st.acc  = (i_st.acc >> 1) + (take ? i_step : '0);
        n_st.root = {i_st.root[pqd_pkg::ROOT_BITS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== design/pqd_assemble.sv =====
// ----------------------------------------------------------------------------
// Packed quaternion decode assembly
// Rounds the roots, applies signs and limits, and places the rebuilt one.
// ----------------------------------------------------------------------------
module pqd_assemble (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [pqd_pkg::ROOT_BITS-1:0]   i_root [pqd_pkg::N_LANES],
    input  pqd_pkg::t_tag                   i_tag,
    output pqd_pkg::t_quat                  o_quat
);

    logic [pqd_pkg::OUT_BITS-1:0]  comp [pqd_pkg::N_LANES];
    pqd_pkg::t_quat                n_quat;
    pqd_pkg::t_quat                r_quat;

    // Nearest integer from the floor root: n = (s + 1) / 2, then limit and sign
    function automatic logic [pqd_pkg::OUT_BITS-1:0] to_fixed(
        input logic [pqd_pkg::ROOT_BITS-1:0] s,
        input logic                          neg
    );
        logic [pqd_pkg::ROOT_BITS:0]   inc;
        logic [pqd_pkg::ROOT_BITS-1:0] mag;
        inc = {1'b0, s} + (pqd_pkg::ROOT_BITS + 1)'(1);
        mag = inc[pqd_pkg::ROOT_BITS:1];
        if (neg) begin
            if (mag > pqd_pkg::ROOT_BITS'(pqd_pkg::NEG_CAP)) begin
                mag = pqd_pkg::ROOT_BITS'(pqd_pkg::NEG_CAP);
            end
            return pqd_pkg::OUT_BITS'(0) - pqd_pkg::OUT_BITS'(mag);
        end else begin
            if (mag > pqd_pkg::ROOT_BITS'(pqd_pkg::POS_CAP)) begin
                mag = pqd_pkg::ROOT_BITS'(pqd_pkg::POS_CAP);
            end
            return pqd_pkg::OUT_BITS'(mag);
        end
    endfunction

    always_comb begin
        for (int i = 0; i < pqd_pkg::N_CODES; i++) begin
            comp[i] = to_fixed(i_root[i], i_tag.neg[i]);
        end
        comp[pqd_pkg::N_CODES] = to_fixed(i_root[pqd_pkg::N_CODES], 1'b0);

        // decoded components keep their code order around the rebuilt one
        unique case (i_tag.slot)
            pqd_pkg::SLOT_W: begin
                n_quat.quat_w = comp[3];
                n_quat.quat_x = comp[0];
                n_quat.quat_y = comp[1];
                n_quat.quat_z = comp[2];
            end
            pqd_pkg::SLOT_X: begin
                n_quat.quat_w = comp[0];
                n_quat.quat_x = comp[3];
                n_quat.quat_y = comp[1];
                n_quat.quat_z = comp[2];
            end
            pqd_pkg::SLOT_Y: begin
                n_quat.quat_w = comp[0];
                n_quat.quat_x = comp[1];
                n_quat.quat_y = comp[3];
                n_quat.quat_z = comp[2];
            end
            pqd_pkg::SLOT_Z: begin
                n_quat.quat_w = comp[0];
                n_quat.quat_x = comp[1];
                n_quat.quat_y = comp[2];
                n_quat.quat_z = comp[3];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quat <= n_quat;
        end
    end

    assign o_quat = r_quat;

endmodule

// ===== design/packed_quaternion_decode_top.sv =====
// ----------------------------------------------------------------------------
// Packed quaternion decode top level
// Smallest-three 10-10-10-2 rotation word to a Q1.15 quaternion, streaming.
// ----------------------------------------------------------------------------
// One packed 32-bit rotation word goes in per item and one quaternion (w, x,
// y, z, signed Q1.15, rounded to nearest, ties away from zero) comes out per
// item, in order. The block takes a new item every clock cycle while its
// input ready is high. The first front-end stage loads at the accepting
// edge, and the item then passes, in this order, through the second
// front-end stage, a chain of 16 root cells per component (one cell per
// result bit, each cell an add, a compare and a subtract on a 52-bit
// remainder), one assembly stage and the output register. All four
// components run in parallel lanes of cells, so the chain is fully
// pipelined. An output register and a one-item skid register sit behind the
// chain: input ready drops only after the output has stalled with a second
// item arriving, and returns right after the edge at which the held item
// moves up into the output register. There is no configuration and no state
// that outlives an item.
// ----------------------------------------------------------------------------
`include "packed_quaternion_decode_top_assert.svh"

module packed_quaternion_decode_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pqd_rot_if.sink      i_rot,
    pqd_quat_if.source   o_quat
);

    // Valid flags: two front stages, the root chain, the assembly stage
    localparam int PIPE = pqd_pkg::ROOT_BITS + 3;

    logic                              pipe_en;
    logic [PIPE-1:0]                   r_vld;

    logic [pqd_pkg::V_BITS-1:0]        front_v [pqd_pkg::N_LANES];
    pqd_pkg::t_tag                     front_tag;
    pqd_pkg::t_tag                     r_tag [pqd_pkg::ROOT_BITS];

    pqd_pkg::t_root_st                 chain [pqd_pkg::N_LANES][pqd_pkg::ROOT_BITS+1];
    logic [pqd_pkg::ROOT_BITS-1:0]     roots [pqd_pkg::N_LANES];

    pqd_pkg::t_quat                    pipe_quat;
    pqd_pkg::t_quat                    r_out;
    pqd_pkg::t_quat                    r_skid;
    logic                              r_out_vld;
    logic                              r_skid_vld;

    // Advance the whole pipe unless the skid register holds an item
    assign pipe_en     = !r_skid_vld;
    assign i_rot.ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[PIPE-2:0], i_rot.valid};
        end
    end

    // Split codes, square them, form the remainder for the rebuilt component
    pqd_front u_front (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_word (i_rot.packed_rotation),
        .o_v    (front_v),
        .o_tag  (front_tag)
    );

    // Carry slot and signs beside the root chain
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_tag[0] <= front_tag;
            for (int j = 1; j < pqd_pkg::ROOT_BITS; j++) begin
                r_tag[j] <= r_tag[j-1];
            end
        end
    end

    // One lane of root cells per component, most significant bit first
    for (genvar l = 0; l < pqd_pkg::N_LANES; l++) begin : g_lane
        assign chain[l][0] = '{rem:  {front_v[l], {pqd_pkg::SHIFT{1'b0}}},
                               acc:  '0,
                               root: '0};

        for (genvar j = 0; j < pqd_pkg::ROOT_BITS; j++) begin : g_cell
            localparam pqd_pkg::t_wide STEP =
                pqd_pkg::t_wide'(pqd_pkg::DEN) << (2 * (pqd_pkg::ROOT_BITS - 1 - j));

            pqd_root_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (pipe_en),
                .i_step (STEP),
                .i_st   (chain[l][j]),
                .o_st   (chain[l][j+1])
            );
        end

        assign roots[l] = chain[l][pqd_pkg::ROOT_BITS].root;
    end

    // Round, sign, limit and order the four components
    pqd_assemble u_assemble (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_root (roots),
        .i_tag  (r_tag[pqd_pkg::ROOT_BITS-1]),
        .o_quat (pipe_quat)
    );

    // Output register with one skid entry: drain skid first, else take the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || o_quat.ready) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out      <= pipe_quat;
                    r_out_vld  <= r_vld[PIPE-1];
                end
            end else if (pipe_en && r_vld[PIPE-1]) begin
                // output stalled: hold the arriving item in the skid
                r_skid     <= pipe_quat;
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_quat.valid  = r_out_vld;
    assign o_quat.quat_w = r_out.quat_w;
    assign o_quat.quat_x = r_out.quat_x;
    assign o_quat.quat_y = r_out.quat_y;
    assign o_quat.quat_z = r_out.quat_z;

    `PQD_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld |-> r_out_vld, "skid holds an item while output is empty")
    `PQD_ASSERT(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_vld) |-> $past(r_out_vld && !o_quat.ready), "skid filled without an output stall")
    `PQD_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, r_out_vld && o_quat.ready && !r_skid_vld && !r_vld[PIPE-1], !r_out_vld, "item repeated on output")
    `PQD_ASSERT_NEXT(a_pipe_holds, i_clk, i_rst_n, !i_rot.ready, $stable(r_vld), "pipe moved while stalled")

endmodule
